### hw/rtl/gray_encoder_to_electrical_angle_assert.svh
// Assertion macros for the encoder-to-angle RTL, used by ge2ea_core.
// Plain text, no dependencies; include by bare file name.
`ifndef GRAY_ENCODER_TO_ELECTRICAL_ANGLE_ASSERT_SVH
`define GRAY_ENCODER_TO_ELECTRICAL_ANGLE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GE2EA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define GE2EA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/ge2ea_pkg.sv
// Constants, types and helper functions for the encoder-to-angle block.
// No dependencies; used by every module of the block but ge2ea_ram.
package ge2ea_pkg;

   // encoder and table geometry
   localparam int POSITION_BITS   = 10;
   localparam int SEGMENT_COUNT   = 14;
   localparam int TABLE_DEPTH     = SEGMENT_COUNT + 1;
   localparam int TABLE_ADDR_BITS = $clog2(TABLE_DEPTH);
   localparam int BP_BITS         = POSITION_BITS + 1;

   // angle, velocity and divider widths
   localparam int DEGREES     = 360;
   localparam int ANGLE_BITS  = 9;
   localparam int VEL_BITS    = POSITION_BITS + 1;
   localparam int NUM_BITS    = POSITION_BITS + ANGLE_BITS;
   localparam int DEN_BITS    = BP_BITS;

   // register file
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-3:0] REG_PHASE_OFFSET = '0;
   localparam logic [POSITION_BITS-1:0] PHASE_OFFSET_RESET = POSITION_BITS'(7);

   // divider request and status
   typedef struct packed {
      logic                start;
      logic [NUM_BITS-1:0] dividend;
      logic [DEN_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [ANGLE_BITS-1:0] quotient;
   } div_rsp_type;

   // Gray code to binary: each bit is the XOR of all Gray bits at or above it
   function automatic logic [POSITION_BITS-1:0] gray_to_bin(
      input logic [POSITION_BITS-1:0] g
   );
      logic [POSITION_BITS-1:0] b;
      b[POSITION_BITS-1] = g[POSITION_BITS-1];
      for (int i = POSITION_BITS - 2; i >= 0; i--) begin
         b[i] = b[i+1] ^ g[i];
      end
      return b;
   endfunction

   // breakpoints loaded into the table memory after reset
   function automatic logic [BP_BITS-1:0] bp_rom(
      input logic [TABLE_ADDR_BITS-1:0] addr
   );
      logic [BP_BITS-1:0] v;
      case (addr)
         4'd0:    v = 11'd0;
         4'd1:    v = 11'd72;
         4'd2:    v = 11'd146;
         4'd3:    v = 11'd220;
         4'd4:    v = 11'd292;
         4'd5:    v = 11'd364;
         4'd6:    v = 11'd439;
         4'd7:    v = 11'd513;
         4'd8:    v = 11'd584;
         4'd9:    v = 11'd658;
         4'd10:   v = 11'd731;
         4'd11:   v = 11'd804;
         4'd12:   v = 11'd876;
         4'd13:   v = 11'd950;
         4'd14:   v = 11'd1024;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### hw/rtl/ge2ea_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ge2ea_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/ge2ea_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on ge2ea_pkg for widths and the request/status structs.
module ge2ea_div
   import ge2ea_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [DEN_BITS:0]   trial;

   // one shift-subtract step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quo_ff[NUM_BITS-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(NUM_BITS);
         quo_in  = div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_BITS'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_BITS-1:0];
            quo_in = {quo_ff[NUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   // quotient never exceeds the degree range, so the low bits carry it all
   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff[ANGLE_BITS-1:0];

endmodule

### hw/rtl/ge2ea_core.sv
// Sequencer: table fill, Gray decode, segment scan over the table memory,
// interpolation through the divider, velocity, and the result register.
// Depends on ge2ea_pkg and the assertion macro header.
`include "gray_encoder_to_electrical_angle_assert.svh"

module ge2ea_core
   import ge2ea_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic [POSITION_BITS-1:0]    phase_offset,
   // input channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [POSITION_BITS-1:0]    req_pin_levels,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [POSITION_BITS-1:0]    rsp_position,
   output logic [ANGLE_BITS-1:0]       rsp_angle_deg,
   output logic                        rsp_angle_valid,
   output logic signed [VEL_BITS-1:0]  rsp_velocity,
   // table memory
   output logic                        ram_wr_en,
   output logic [TABLE_ADDR_BITS-1:0]  ram_wr_addr,
   output logic [BP_BITS-1:0]          ram_wr_data,
   output logic                        ram_rd_en,
   output logic [TABLE_ADDR_BITS-1:0]  ram_rd_addr,
   input  logic [BP_BITS-1:0]          ram_rd_data,
   // divider
   output div_req_type                 div_req,
   input  div_rsp_type                 div_rsp
);

   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_SCAN,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   localparam logic signed [VEL_BITS:0] VEL_HALF  = (VEL_BITS+1)'(1 << (POSITION_BITS-1));
   localparam logic signed [VEL_BITS:0] VEL_RANGE = (VEL_BITS+1)'(1 << POSITION_BITS);
   localparam logic [ANGLE_BITS-1:0]    DEG_MAX   = ANGLE_BITS'(DEGREES);
   localparam logic [TABLE_ADDR_BITS-1:0] LAST_ENTRY = TABLE_ADDR_BITS'(SEGMENT_COUNT);

   state_type                    state_ff, state_in;
   logic [TABLE_ADDR_BITS-1:0]   fill_addr_ff, fill_addr_in;
   logic [TABLE_ADDR_BITS-1:0]   rd_idx_ff, rd_idx_in;
   logic [POSITION_BITS-1:0]     last_pos_ff, last_pos_in;
   logic [POSITION_BITS-1:0]     pos_ff, pos_in;
   logic [POSITION_BITS-1:0]     x_ff, x_in;
   logic [VEL_BITS-1:0]          vel_ff, vel_in;
   logic [BP_BITS-1:0]           lo_ff, lo_in;
   logic [NUM_BITS-1:0]          num_ff, num_in;
   logic [DEN_BITS-1:0]          den_ff, den_in;
   logic                         div_start_ff, div_start_in;
   logic [ANGLE_BITS-1:0]        angle_ff, angle_in;
   logic                         match_ff, match_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [POSITION_BITS-1:0]     rsp_pos_ff, rsp_pos_in;
   logic [ANGLE_BITS-1:0]        rsp_angle_ff, rsp_angle_in;
   logic                         rsp_match_ff, rsp_match_in;
   logic [VEL_BITS-1:0]          rsp_vel_ff, rsp_vel_in;

   logic                         accept;
   logic                         rsp_free;
   logic [POSITION_BITS-1:0]     pos_dec;
   logic signed [VEL_BITS:0]     vel_raw;
   logic signed [VEL_BITS:0]     vel_adj;
   logic [BP_BITS-1:0]           x_ext;
   logic                         seg_hit;
   logic [BP_BITS-1:0]           x_minus_lo;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // decode and wrap the position difference
   always_comb begin
      pos_dec = gray_to_bin(~req_pin_levels);
      vel_raw = $signed({2'b00, pos_dec}) - $signed({2'b00, last_pos_ff});
      vel_adj = vel_raw;
      if (vel_raw > VEL_HALF) begin
         vel_adj = vel_raw - VEL_RANGE;
      end else if (vel_raw < -VEL_HALF) begin
         vel_adj = vel_raw + VEL_RANGE;
      end
   end

   // segment test: previous entry is the lower bound, the arriving one the upper
   assign x_ext      = {1'b0, x_ff};
   assign seg_hit    = (x_ext >= lo_ff) && (x_ext < ram_rd_data);
   assign x_minus_lo = x_ext - lo_ff;

   // next-state and datapath
   always_comb begin
      state_in     = state_ff;
      fill_addr_in = fill_addr_ff;
      rd_idx_in    = rd_idx_ff;
      last_pos_in  = last_pos_ff;
      pos_in       = pos_ff;
      x_in         = x_ff;
      vel_in       = vel_ff;
      lo_in        = lo_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      div_start_in = 1'b0;
      angle_in     = angle_ff;
      match_in     = match_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_angle_in = rsp_angle_ff;
      rsp_match_in = rsp_match_ff;
      rsp_vel_in   = rsp_vel_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = fill_addr_ff;
      ram_wr_data  = bp_rom(fill_addr_ff);
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;

      // result register empties when taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_FILL: begin
            ram_wr_en    = 1'b1;
            fill_addr_in = fill_addr_ff + 1'b1;
            if (fill_addr_ff == LAST_ENTRY) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               pos_in      = pos_dec;
               x_in        = pos_dec - phase_offset;
               vel_in      = vel_adj[VEL_BITS-1:0];
               last_pos_in = pos_dec;
               ram_rd_en   = 1'b1;
               rd_idx_in   = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_idx_ff != '0 && seg_hit) begin
               num_in       = NUM_BITS'(x_minus_lo[POSITION_BITS-1:0]) *
                              NUM_BITS'(DEGREES);
               den_in       = ram_rd_data - lo_ff;
               div_start_in = 1'b1;
               state_in     = ST_DIVIDE;
            end else if (rd_idx_ff == LAST_ENTRY) begin
               angle_in = '0;
               match_in = 1'b0;
               state_in = ST_DONE;
            end else begin
               lo_in       = ram_rd_data;
               ram_rd_en   = 1'b1;
               ram_rd_addr = rd_idx_ff + 1'b1;
               rd_idx_in   = rd_idx_ff + 1'b1;
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               // reverse direction; a full turn folds to zero
               angle_in = (div_rsp.quotient == '0) ? '0 : DEG_MAX - div_rsp.quotient;
               match_in = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = pos_ff;
               rsp_angle_in = angle_ff;
               rsp_match_in = match_ff;
               rsp_vel_in   = vel_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state, control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         fill_addr_ff <= '0;
         last_pos_ff  <= '0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_addr_ff <= fill_addr_in;
         last_pos_ff  <= last_pos_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff    <= rd_idx_in;
      pos_ff       <= pos_in;
      x_ff         <= x_in;
      vel_ff       <= vel_in;
      lo_ff        <= lo_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      angle_ff     <= angle_in;
      match_ff     <= match_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_match_ff <= rsp_match_in;
      rsp_vel_ff   <= rsp_vel_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_angle_deg    = rsp_angle_ff;
   assign rsp_angle_valid  = rsp_match_ff;
   assign rsp_velocity     = $signed(rsp_vel_ff);

   assign div_req.start    = div_start_ff;
   assign div_req.dividend = num_ff;
   assign div_req.divisor  = den_ff;

   // checks
   `GE2EA_ASSERT_NOW(a_div_start_idle, clock, reset, div_req.start, !div_rsp.busy,
      "divider started while busy")
   `GE2EA_ASSERT_NEXT(a_div_runs, clock, reset, div_req.start, div_rsp.busy,
      "divider did not take the start")
   `GE2EA_ASSERT_NOW(a_div_done_state, clock, reset, div_rsp.done,
      (state_ff == ST_DIVIDE) && (div_rsp.quotient < DEG_MAX),
      "divider result out of place or range")
   `GE2EA_ASSERT_NOW(a_invalid_zero, clock, reset, rsp_valid_ff && !rsp_match_ff,
      rsp_angle_ff == '0, "invalid angle not zero")
   `GE2EA_ASSERT_NOW(a_vel_range, clock, reset, rsp_valid_ff,
      ($signed(rsp_vel_ff) <= VEL_HALF) && ($signed(rsp_vel_ff) >= -VEL_HALF),
      "velocity outside half range")

endmodule

### hw/rtl/gray_encoder_to_electrical_angle.sv
// Top level: register port, table memory, divider and sequencer.
// Depends on ge2ea_pkg, ge2ea_ram, ge2ea_div and ge2ea_core.
//
//   channel   direction  handshake          payload
//   req_      in         valid / stall      pin_levels[9:0]
//   rsp_      out        valid / stall      position, angle_deg, angle_valid, velocity
//   csr_      in/out     psel/penable/...   phase_offset at byte address 0
//
// After reset the breakpoint table is loaded into memory; items are stalled
// until then, register writes are taken throughout.
// One item at a time: the scan reads one table entry per cycle from the
// memory port, then for a hit the serial divider runs from start to done;
// a miss, where no segment holds the item, skips the divider.
// The next item is taken in the cycle after the result is loaded; a result still
// waiting in the output register holds the finished item until it is taken.
module gray_encoder_to_electrical_angle
   import ge2ea_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   // input channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [POSITION_BITS-1:0]    req_pin_levels,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [POSITION_BITS-1:0]    rsp_position,
   output logic [ANGLE_BITS-1:0]       rsp_angle_deg,
   output logic                        rsp_angle_valid,
   output logic signed [VEL_BITS-1:0]  rsp_velocity,
   // register port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                        csr_pready
);

   logic [POSITION_BITS-1:0]   phase_offset_ff, phase_offset_in;
   logic                       csr_hit;
   logic                       ram_wr_en;
   logic [TABLE_ADDR_BITS-1:0] ram_wr_addr;
   logic [BP_BITS-1:0]         ram_wr_data;
   logic                       ram_rd_en;
   logic [TABLE_ADDR_BITS-1:0] ram_rd_addr;
   logic [BP_BITS-1:0]         ram_rd_data;
   div_req_type                div_req;
   div_rsp_type                div_rsp;

   // register port: always ready, one register
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_BITS-1:2] == REG_PHASE_OFFSET);

   always_comb begin
      phase_offset_in = phase_offset_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         phase_offset_in = csr_pwdata[POSITION_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_offset_ff <= PHASE_OFFSET_RESET;
      end else begin
         phase_offset_ff <= phase_offset_in;
      end
   end

   assign csr_prdata = csr_hit ? CSR_DATA_BITS'(phase_offset_ff) : '0;

   // breakpoint table
   ge2ea_ram #(
      .WIDTH (BP_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // interpolation divider
   ge2ea_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // sequencer
   ge2ea_core u_core (
      .clock           (clock),
      .reset           (reset),
      .phase_offset    (phase_offset_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pin_levels  (req_pin_levels),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_position    (rsp_position),
      .rsp_angle_deg   (rsp_angle_deg),
      .rsp_angle_valid (rsp_angle_valid),
      .rsp_velocity    (rsp_velocity),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .div_req         (div_req),
      .div_rsp         (div_rsp)
   );

endmodule

### tb/tb_top.sv
// Self-checking testbench for gray_encoder_to_electrical_angle: encoder samples in,
// position / angle / velocity out, with the phase offset set over the register port.
// Depends on ge2ea_pkg and the RTL of the block only.
module tb_top
   import ge2ea_pkg::*;
;

   // expected result of one encoder sample
   typedef struct packed {
      logic [POSITION_BITS-1:0] position;
      logic [ANGLE_BITS-1:0]    angle_deg;
      logic                     angle_valid;
      logic [VEL_BITS-1:0]      velocity;
   } angle_result_type;

   localparam int STUCK_LIMIT = 3000;
   localparam int IDLE_PCT    = 13;
   localparam int POS_RANGE   = 1 << POSITION_BITS;
   localparam int POS_HALF    = POS_RANGE / 2;
   localparam logic [CSR_ADDR_BITS-1:0] OFFSET_ADDR =
      CSR_ADDR_BITS'({REG_PHASE_OFFSET, 2'b00});
   // segment bounds of the built-in breakpoint table
   localparam int unsigned SEGMENT_BOUNDS [0:TABLE_DEPTH-1] = '{
      0, 72, 146, 220, 292, 364, 439, 513, 584, 658, 731, 804, 876, 950, 1024
   };

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [POSITION_BITS-1:0]   req_pin_levels;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [POSITION_BITS-1:0]   rsp_position;
   logic [ANGLE_BITS-1:0]      rsp_angle_deg;
   logic                       rsp_angle_valid;
   logic signed [VEL_BITS-1:0] rsp_velocity;
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [CSR_ADDR_BITS-1:0]   csr_paddr;
   logic [CSR_DATA_BITS-1:0]   csr_pwdata;
   logic [CSR_DATA_BITS-1:0]   csr_prdata;
   logic                       csr_pready;

   // predictor state
   logic [POSITION_BITS-1:0]   model_offset;
   logic [POSITION_BITS-1:0]   model_last_pos;
   angle_result_type           pending_angles[$];
   int                         error_count;
   int                         stuck_cycles;
   bit                         no_idle;

   gray_encoder_to_electrical_angle uut (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // print one mismatch line and count it
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
   endtask

   // pins that the encoder shows at a given binary position
   function automatic logic [POSITION_BITS-1:0] pins_for(input logic [POSITION_BITS-1:0] p);
      return ~(p ^ (p >> 1));
   endfunction

   // decode one sample against the current offset and previous position
   function automatic angle_result_type decode_sample(input logic [POSITION_BITS-1:0] pins);
      angle_result_type         r;
      logic [POSITION_BITS-1:0] g;
      logic [POSITION_BITS-1:0] pos;
      logic [POSITION_BITS-1:0] x;
      int unsigned              lo;
      int unsigned              hi;
      int unsigned              a;
      int                       delta;
      g = ~pins;
      for (int i = 0; i < POSITION_BITS; i++)
         pos[i] = ^(g >> i);
      x = pos - model_offset;
      r.position    = pos;
      r.angle_deg   = '0;
      r.angle_valid = 1'b0;
      // first segment that holds x wins
      for (int s = 0; s < SEGMENT_COUNT; s++) begin
         lo = SEGMENT_BOUNDS[s];
         hi = SEGMENT_BOUNDS[s+1];
         if (!r.angle_valid && x >= lo && x < hi) begin
            a = ((x - lo) * DEGREES) / (hi - lo);
            a = DEGREES - a;
            if (a == DEGREES)
               a = 0;
            r.angle_deg   = ANGLE_BITS'(a);
            r.angle_valid = 1'b1;
         end
      end
      // velocity wrapped into the half range, +-half kept as is
      delta = int'(pos) - int'(model_last_pos);
      if (delta > POS_HALF)
         delta -= POS_RANGE;
      if (delta < -POS_HALF)
         delta += POS_RANGE;
      r.velocity = VEL_BITS'(delta);
      return r;
   endfunction

   // send one sample, possibly after a random gap; valid stays high afterwards
   task automatic send_pins(input logic [POSITION_BITS-1:0] pins);
      angle_result_type r;
      if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_pin_levels <= pins;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      r = decode_sample(pins);
      model_last_pos = r.position;
      pending_angles.push_back(r);
   endtask

   task automatic send_position(input logic [POSITION_BITS-1:0] p);
      send_pins(pins_for(p));
   endtask

   // stop sending and wait until every expected result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_angles.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write: setup cycle, then access cycle
   task automatic write_offset(input logic [POSITION_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= OFFSET_ADDR;
      csr_pwdata  <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      model_offset = value;
   endtask

   // register read, checked against the predictor's copy
   task automatic check_offset_readback();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= OFFSET_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if (csr_prdata !== CSR_DATA_BITS'(model_offset))
         report_mismatch("phase_offset readback", csr_prdata, CSR_DATA_BITS'(model_offset));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // change the offset between phases, block idle
   task automatic set_offset(input logic [POSITION_BITS-1:0] value);
      wait_drained();
      write_offset(value);
      check_offset_readback();
   endtask

   // reset offset: pins all high, all low, electrical zero
   task automatic test_power_on_offset();
      check_offset_readback();
      send_pins('1);
      send_pins('0);
      send_position(POSITION_BITS'(PHASE_OFFSET_RESET));
   endtask

   // offset zero: start of every segment, both ends of the outer ones
   task automatic test_segment_bounds();
      set_offset('0);
      for (int s = 0; s < SEGMENT_COUNT; s++)
         send_position(POSITION_BITS'(SEGMENT_BOUNDS[s]));
      send_position(POSITION_BITS'(SEGMENT_BOUNDS[1] - 1));
      send_position('1);
   endtask

   // half-range jumps kept, jumps past half range wrapped
   task automatic test_velocity_wrap();
      send_position('0);
      send_position(POSITION_BITS'(POS_HALF));
      send_position('0);
      send_position(POSITION_BITS'(POS_HALF + 1));
      send_position('0);
      send_position(POSITION_BITS'(POS_HALF - 1));
   endtask

   // a turning shaft: small steps, some half-range jumps, some noise samples
   task automatic test_rotation(input logic [POSITION_BITS-1:0] offset, input int count,
                                input bit quiet);
      int                       pick;
      logic [POSITION_BITS-1:0] pos;
      set_offset(offset);
      no_idle = quiet;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 9);
         pos  = model_last_pos;
         if (pick == 0) begin
            send_pins(POSITION_BITS'($urandom));
         end else if (pick == 1) begin
            send_position(pos + POSITION_BITS'(POS_HALF - 1 + $urandom_range(0, 2)));
         end else begin
            send_position(pos + POSITION_BITS'($urandom_range(0, 16) - 8));
         end
      end
      no_idle = 1'b0;
   endtask

   // result check against the oldest expectation
   always @(posedge clock) begin
      angle_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_angles.size() == 0) begin
            report_mismatch("result with nothing expected, position", 32'(rsp_position), '0);
         end else begin
            want = pending_angles.pop_front();
            if (rsp_position !== want.position)
               report_mismatch("position", 32'(rsp_position), 32'(want.position));
            if (rsp_angle_deg !== want.angle_deg)
               report_mismatch("angle_deg", 32'(rsp_angle_deg), 32'(want.angle_deg));
            if (rsp_angle_valid !== want.angle_valid)
               report_mismatch("angle_valid", 32'(rsp_angle_valid), 32'(want.angle_valid));
            if (rsp_velocity !== want.velocity)
               report_mismatch("velocity", 32'(rsp_velocity), 32'(want.velocity));
         end
      end
   end

   // random stall on the result side
   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
   end

   // watchdog: cycles in a row with nothing accepted on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // test sequence
   initial begin
      error_count    = 0;
      no_idle        = 1'b0;
      model_offset   = POSITION_BITS'(PHASE_OFFSET_RESET);
      model_last_pos = '0;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_pin_levels <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_power_on_offset();
      test_segment_bounds();
      test_velocity_wrap();
      test_rotation('1, 110, 1'b0);
      test_rotation(POSITION_BITS'($urandom), 110, 1'b0);
      test_rotation('0, 110, 1'b1);
      test_rotation(POSITION_BITS'(PHASE_OFFSET_RESET), 110, 1'b0);
      test_rotation(POSITION_BITS'($urandom), 110, 1'b0);

      wait_drained();
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
